FILE: rtl/core/pot_pkg.sv
// Shared types and constants for the port open table.
// Used by pot_ctrl, pot_dp and port_open_table; depends on nothing else.
package pot_pkg;

   // Width of a network port number.
   localparam int PORT_W = 16;

   // Default number of table slots.
   localparam int PORT_SLOTS_DEF = 16;

   // A list request reports at most this many open ports.
   localparam int LIST_LIMIT = 16;
   localparam int LIST_CNT_W = $clog2(LIST_LIMIT + 1);

   // Request codes.
   typedef enum logic [1:0] {
      OP_QUERY = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_LIST  = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_NOT_OPEN = 2'd2
   } status_type;

   // One request beat.
   typedef struct packed {
      op_type              op;
      logic [PORT_W-1:0]   port;
   } req_type;

   // One result beat.
   typedef struct packed {
      status_type          status;
      logic                found;
      logic [PORT_W-1:0]   port_out;
      logic                last;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_SCAN  = 2'd1,
      FSM_REPLY = 2'd2
   } fsm_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic reply_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic done;
      logic stall;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/core/pot_ctrl.sv
// Sequencer for the port open table: accepts a request, runs the slot scan
// and hands the final result to the output register. Depends on pot_pkg.
module pot_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output pot_pkg::cmd_type  cmd,
   input  pot_pkg::stat_type stat
);
   import pot_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (!stat.stall && stat.done) begin
               state_in = FSM_REPLY;
            end
         end
         FSM_REPLY: begin
            if (stat.out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready      = 1'b0;
      cmd.start      = 1'b0;
      cmd.step       = 1'b0;
      cmd.reply_load = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         FSM_SCAN: begin
            cmd.step = !stat.stall;
         end
         FSM_REPLY: begin
            cmd.reply_load = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // A taken request always enters the scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == FSM_SCAN)
      else $error("start did not enter the scan");

   // The final result is loaded exactly once, then the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.reply_load |=> state_ff == FSM_IDLE && !cmd.reply_load)
      else $error("final result loaded twice");

   // Scan steps never happen outside a request.
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_ready && !cmd.start && !cmd.reply_load)
      else $error("commands overlap");

endmodule

FILE: rtl/core/pot_dp.sv
// Datapath of the port open table: slot memory, per-slot valid bits, the
// scan pipeline, list holding register and result register. Uses pot_pkg.
module pot_dp #(
   parameter int PORT_SLOTS = pot_pkg::PORT_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  pot_pkg::req_type  req_data,
   output pot_pkg::rsp_type  rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pot_pkg::cmd_type  cmd,
   output pot_pkg::stat_type stat
);
   import pot_pkg::*;

   localparam int IDX_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int CNT_W = $clog2(PORT_SLOTS + 1);

   // Slot contents; only meaningful where the valid bit is set.
   logic [PORT_W-1:0]     slot_mem [PORT_SLOTS];

   logic [PORT_SLOTS-1:0] valid_ff, valid_in;
   req_type               req_ff, req_in;
   logic [CNT_W-1:0]      issue_cnt_ff, issue_cnt_in;
   logic [IDX_W-1:0]      eval_idx_ff, eval_idx_in;
   logic                  eval_live_ff, eval_live_in;
   logic [PORT_W-1:0]     rd_data_ff;
   logic                  hit_ff, hit_in;
   logic [PORT_W-1:0]     hold_ff, hold_in;
   logic                  hold_full_ff, hold_full_in;
   logic [LIST_CNT_W-1:0] list_cnt_ff, list_cnt_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic             issue;
   logic [IDX_W-1:0] issue_idx;
   logic             ev;
   logic             match;
   logic             close_all;
   logic             hit_evt;
   logic             list_take;
   logic             list_emit;
   logic             limit_hit;
   logic             out_free;
   logic             mem_wr;
   rsp_type          reply;

   // Scan decisions for the slot in the evaluate stage.
   always_comb begin
      issue     = issue_cnt_ff < CNT_W'(PORT_SLOTS);
      issue_idx = issue_cnt_ff[IDX_W-1:0];
      ev        = valid_ff[eval_idx_ff];
      match     = ev && (rd_data_ff == req_ff.port);
      close_all = (req_ff.op == OP_CLOSE) && (req_ff.port == '0);
      hit_evt   = 1'b0;
      list_take = 1'b0;
      unique case (req_ff.op)
         OP_QUERY: hit_evt   = eval_live_ff && match;
         OP_OPEN:  hit_evt   = eval_live_ff && !ev;
         OP_CLOSE: hit_evt   = eval_live_ff && match && !close_all;
         OP_LIST:  list_take = eval_live_ff && ev;
         default:  hit_evt   = 1'b0;
      endcase
      list_emit = list_take && hold_full_ff;
      limit_hit = list_take && (list_cnt_ff == LIST_CNT_W'(LIST_LIMIT - 1));
      out_free  = !rsp_valid_ff || rsp_ready;
      mem_wr    = cmd.step && hit_evt && (req_ff.op == OP_OPEN) && (req_ff.port != '0);

      stat.done     = close_all || hit_evt || limit_hit || (!eval_live_ff && !issue);
      stat.stall    = list_emit && !out_free;
      stat.out_free = out_free;
   end

   // Final result of the request, built from what the scan left behind.
   always_comb begin
      reply.status   = STS_OK;
      reply.found    = 1'b0;
      reply.port_out = '0;
      reply.last     = 1'b1;
      unique case (req_ff.op)
         OP_QUERY: begin
            reply.found = hit_ff;
         end
         OP_OPEN: begin
            reply.status = hit_ff ? STS_OK : STS_FULL;
         end
         OP_CLOSE: begin
            reply.status = hit_ff ? STS_OK : STS_NOT_OPEN;
         end
         OP_LIST: begin
            reply.found    = hold_full_ff;
            reply.port_out = hold_full_ff ? hold_ff : '0;
         end
         default: begin
            reply.status = STS_OK;
         end
      endcase
   end

   // Next values of the scan and table state.
   always_comb begin
      valid_in     = valid_ff;
      req_in       = req_ff;
      issue_cnt_in = issue_cnt_ff;
      eval_idx_in  = eval_idx_ff;
      eval_live_in = eval_live_ff;
      hit_in       = hit_ff;
      hold_in      = hold_ff;
      hold_full_in = hold_full_ff;
      list_cnt_in  = list_cnt_ff;
      if (cmd.start) begin
         req_in       = req_data;
         issue_cnt_in = '0;
         eval_live_in = 1'b0;
         hit_in       = 1'b0;
         hold_full_in = 1'b0;
         list_cnt_in  = '0;
      end else if (cmd.step) begin
         eval_live_in = issue;
         if (issue) begin
            eval_idx_in  = issue_idx;
            issue_cnt_in = issue_cnt_ff + CNT_W'(1);
         end
         if (hit_evt || close_all) begin
            hit_in = 1'b1;
         end
         if (close_all) begin
            valid_in = '0;
         end else if (hit_evt && req_ff.op == OP_CLOSE) begin
            valid_in[eval_idx_ff] = 1'b0;
         end else if (mem_wr) begin
            valid_in[eval_idx_ff] = 1'b1;
         end
         if (list_take) begin
            hold_in      = rd_data_ff;
            hold_full_in = 1'b1;
            list_cnt_in  = list_cnt_ff + LIST_CNT_W'(1);
         end
      end
   end

   // Result register: list entries during the scan, final beat afterwards.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.step && list_emit) begin
         rsp_in.status   = STS_OK;
         rsp_in.found    = 1'b1;
         rsp_in.port_out = hold_ff;
         rsp_in.last     = 1'b0;
         rsp_valid_in    = 1'b1;
      end else if (cmd.reply_load) begin
         rsp_in       = reply;
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         eval_live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         list_cnt_ff  <= '0;
      end else begin
         valid_ff     <= valid_in;
         eval_live_ff <= eval_live_in;
         rsp_valid_ff <= rsp_valid_in;
         list_cnt_ff  <= list_cnt_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      issue_cnt_ff <= issue_cnt_in;
      eval_idx_ff  <= eval_idx_in;
      hit_ff       <= hit_in;
      hold_ff      <= hold_in;
      hold_full_ff <= hold_full_in;
      rsp_ff       <= rsp_in;
   end

   // Slot memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         slot_mem[eval_idx_ff] <= req_ff.port;
      end
      if (cmd.step && issue) begin
         rd_data_ff <= slot_mem[issue_idx];
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // A result beat is never loaded over one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      ((cmd.step && list_emit) || cmd.reply_load) |-> out_free)
      else $error("result register overwritten");

   // Closing port zero leaves every slot free.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.step && close_all) |=> valid_ff == '0)
      else $error("close all left a slot open");

   // The list never holds more entries than the limit.
   assert property (@(posedge clock) disable iff (reset)
      list_cnt_ff <= LIST_CNT_W'(LIST_LIMIT))
      else $error("list count beyond limit");

   // An open of a real port marks its slot as taken.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr |=> valid_ff[$past(eval_idx_ff)])
      else $error("opened slot not marked valid");

endmodule

FILE: rtl/core/port_open_table.sv
// Port open table: a table of PORT_SLOTS slots holding open network ports,
// each request answered by a scan that reads one slot per cycle (unless a
// list beat stalls it) from the slot memory with one write and one read port.
// A request is taken only when the previous one has finished scanning; its
// result beats sit in an output register, so the next request may be taken
// while the last beat still waits. Query, open and close give one beat; list
// gives one beat per open port (at most 16), in slot order, the final one
// marked last, or one empty beat. A hit or a close of port 0 ends the scan
// early. List beats that the consumer does not take stall the scan. All slots
// are free after reset at once, through per-slot valid bits; no clearing
// pass is needed.
module port_open_table #(
   parameter int PORT_SLOTS = pot_pkg::PORT_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pot_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pot_pkg::rsp_type rsp_data
);
   import pot_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   pot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Table and scan datapath.
   pot_dp #(
      .PORT_SLOTS (PORT_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for port_open_table: directed table plus random requests.
// Depends on pot_pkg for the request and result beat types; needs only the RTL.
module testbench;
   import pot_pkg::*;

   localparam int PORT_SLOTS  = PORT_SLOTS_DEF;
   localparam int RANDOM_REQS = 325;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 2 * PORT_SLOTS + 8;
   localparam int SHOWN_FAULTS = 10;

   // One row of the directed table: a request and, where obvious, its single beat.
   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type beat;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the table and the beats it still owes.
   logic [PORT_W-1:0] shadow_slots [PORT_SLOTS];
   logic [PORT_W-1:0] port_pool [8];
   rsp_type           predict_beats [$];
   rsp_type           owed_beats [$];
   dir_row_type       directed_rows [$];
   rsp_type           seen_beat;
   rsp_type           want_beat;

   bit calm = 1'b0;
   int quiet_cycles = 0;
   int fault_count = 0;
   int beats_checked = 0;
   int reqs_sent = 0;
   int full_refusals = 0;
   int absent_closes = 0;

   port_open_table #(
      .PORT_SLOTS(PORT_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // A lone result beat with no port attached.
   function automatic rsp_type single_beat(status_type sts, logic hit);
      return '{status: sts, found: hit, port_out: '0, last: 1'b1};
   endfunction

   // Apply one request to the shadow table and collect the beats it yields.
   function automatic void apply_request(req_type rq);
      logic hit;
      bit   done;
      int   n;
      predict_beats.delete();
      hit  = 1'b0;
      done = 1'b0;
      n    = 0;
      case (rq.op)
         OP_QUERY: begin
            if (rq.port != '0) begin
               for (int i = 0; i < PORT_SLOTS; i++)
                  if (shadow_slots[i] == rq.port) hit = 1'b1;
            end
            predict_beats.push_back(single_beat(STS_OK, hit));
         end
         OP_OPEN: begin
            for (int i = 0; i < PORT_SLOTS; i++) begin
               if (!done && shadow_slots[i] == '0) begin
                  shadow_slots[i] = rq.port;
                  done = 1'b1;
               end
            end
            if (!done) full_refusals++;
            predict_beats.push_back(single_beat(done ? STS_OK : STS_FULL, 1'b0));
         end
         OP_CLOSE: begin
            // Port zero frees the whole table; otherwise the lowest match goes.
            if (rq.port == '0) begin
               for (int i = 0; i < PORT_SLOTS; i++) shadow_slots[i] = '0;
               done = 1'b1;
            end else begin
               for (int i = 0; i < PORT_SLOTS; i++) begin
                  if (!done && shadow_slots[i] == rq.port) begin
                     shadow_slots[i] = '0;
                     done = 1'b1;
                  end
               end
            end
            if (!done) absent_closes++;
            predict_beats.push_back(single_beat(done ? STS_OK : STS_NOT_OPEN, 1'b0));
         end
         default: begin
            for (int i = 0; i < PORT_SLOTS; i++) begin
               if (shadow_slots[i] != '0 && n < LIST_LIMIT) begin
                  predict_beats.push_back('{status: STS_OK, found: 1'b1,
                                            port_out: shadow_slots[i], last: 1'b0});
                  n++;
               end
            end
            if (n == 0) predict_beats.push_back(single_beat(STS_OK, 1'b0));
            else predict_beats[n-1].last = 1'b1;
         end
      endcase
   endfunction

   function automatic void add_row(op_type op, logic [PORT_W-1:0] port, bit typed,
                                   rsp_type beat);
      dir_row_type row;
      row.rq    = '{op: op, port: port};
      row.typed = typed;
      row.beat  = beat;
      directed_rows.push_back(row);
   endfunction

   // Port choice for random requests: mostly ports already open or from a
   // small pool, so that queries and closes hit; sometimes anything; rarely zero.
   function automatic logic [PORT_W-1:0] pick_port();
      logic [PORT_W-1:0] open_ports [$];
      int roll;
      roll = $urandom_range(0, 99);
      for (int i = 0; i < PORT_SLOTS; i++)
         if (shadow_slots[i] != '0) open_ports.push_back(shadow_slots[i]);
      if (roll < 45 && open_ports.size() > 0)
         return open_ports[$urandom_range(0, open_ports.size() - 1)];
      else if (roll < 75)
         return port_pool[$urandom_range(0, 7)];
      else if (roll < 97)
         return PORT_W'($urandom);
      return '0;
   endfunction

   function automatic op_type pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return OP_OPEN;
      if (roll < 65) return OP_CLOSE;
      if (roll < 85) return OP_QUERY;
      return OP_LIST;
   endfunction

   // Offer one request beat, wait for it to be taken, then record what it owes.
   task automatic send_request(req_type rq, bit typed, rsp_type beat);
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 7);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(rq);
      reqs_sent++;
      if (typed) owed_beats.push_back(beat);
      else foreach (predict_beats[k]) owed_beats.push_back(predict_beats[k]);
   endtask

   task automatic report_fault(string what);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS) $display("%s", what);
   endtask

   // Result side: random back-pressure, except in the calm stretch.
   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 7);
   end

   // Result checker and activity counter for the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles = quiet_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            seen_beat = rsp_data;
            if (owed_beats.size() == 0) begin
               report_fault($sformatf("Unexpected result beat: status %0d found %0d port %h last %0d",
                                      seen_beat.status, seen_beat.found,
                                      seen_beat.port_out, seen_beat.last));
            end else begin
               want_beat = owed_beats.pop_front();
               beats_checked++;
               if (seen_beat.status !== want_beat.status || seen_beat.found !== want_beat.found ||
                   seen_beat.port_out !== want_beat.port_out ||
                   seen_beat.last !== want_beat.last) begin
                  report_fault($sformatf(
                     "Beat %0d mismatch: expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                     beats_checked, want_beat.status, want_beat.found, want_beat.port_out,
                     want_beat.last, seen_beat.status, seen_beat.found,
                     seen_beat.port_out, seen_beat.last));
               end
            end
         end
      end
   end

   // Watchdog: too long without any beat moving on either channel.
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Watchdog expired with %0d result beats outstanding.", owed_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Main sequence: reset, directed table, random requests, drain.
   initial begin
      for (int i = 0; i < PORT_SLOTS; i++) shadow_slots[i] = '0;
      for (int i = 0; i < 8; i++) port_pool[i] = PORT_W'($urandom_range(1, 65535));

      // Directed table; typed beats are the ones obvious from an empty or full table.
      add_row(OP_LIST,  16'h0000, 1, single_beat(STS_OK, 1'b0));
      add_row(OP_QUERY, 16'h0000, 1, single_beat(STS_OK, 1'b0));
      add_row(OP_CLOSE, 16'h1234, 1, single_beat(STS_NOT_OPEN, 1'b0));
      add_row(OP_OPEN,  16'hFFFF, 0, '0);
      add_row(OP_OPEN,  16'h0001, 0, '0);
      add_row(OP_OPEN,  16'h0001, 0, '0);
      add_row(OP_OPEN,  16'h0000, 0, '0);
      for (int i = 0; i < PORT_SLOTS - 3; i++)
         add_row(OP_OPEN, PORT_W'(16'h0002 << i), 0, '0);
      add_row(OP_OPEN,  16'h4242, 1, single_beat(STS_FULL, 1'b0));
      add_row(OP_OPEN,  16'h0000, 1, single_beat(STS_FULL, 1'b0));
      add_row(OP_LIST,  16'h0000, 0, '0);
      add_row(OP_CLOSE, 16'h0001, 0, '0);
      add_row(OP_QUERY, 16'h0001, 0, '0);
      add_row(OP_CLOSE, 16'h0000, 1, single_beat(STS_OK, 1'b0));
      add_row(OP_LIST,  16'hFFFF, 1, single_beat(STS_OK, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r])
         send_request(directed_rows[r].rq, directed_rows[r].typed, directed_rows[r].beat);

      // Random requests, with a stretch of back-to-back traffic in the middle.
      for (int n = 0; n < RANDOM_REQS; n++) begin
         calm = (n >= 100 && n < 200);
         send_request('{op: pick_op(), port: pick_port()}, 0, '0);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (owed_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_beats.size() != 0)
         report_fault($sformatf("%0d result beats never arrived.", owed_beats.size()));

      $display("Sent %0d requests and checked %0d result beats.", reqs_sent, beats_checked);
      $display("Predicted %0d full-table refusals and %0d closes of absent ports; %0d faults.",
               full_refusals, absent_closes, fault_count);
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
